// ===== sv/m4a_pkg.sv =====
// Shared types, codes and sizing constants for the 4x4 fixed-point matrix unit.
// Used by every module of the block; no dependencies.
package m4a_pkg;

	localparam int DATA_W        = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_ELEMS     = 16;
	localparam int IDX_W         = 4;
	// Intermediate values are clamped to +-2^LIM_EXP and kept signed in IW bits.
	localparam int LIM_EXP       = 60;
	localparam int IW            = LIM_EXP + 2;
	localparam int PW            = 2 * IW;
	localparam int AW            = PW + 4;
	// Serial multiplier digit size.
	localparam int DIG_W         = 8;
	localparam int NDIG          = (IW + DIG_W - 1) / DIG_W;
	localparam int MB_W          = NDIG * DIG_W;

	typedef enum logic [1:0] {
		KIND_LOAD_A,
		KIND_LOAD_B,
		KIND_START
	} kind_t;

	typedef enum logic [2:0] {
		OP_MUL,
		OP_ADD,
		OP_SUB,
		OP_SCALE,
		OP_DIV,
		OP_TRANS,
		OP_DET
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_SAT,
		STAT_DIVZ
	} stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIVZ,
		S_READ,
		S_EXEC,
		S_WAIT
	} state_t;

	// Determinant sub-steps: two minor products, the 3x3 term, the 4x4 term.
	typedef enum logic [1:0] {
		PH_MIN0,
		PH_MIN1,
		PH_D3,
		PH_D4
	} dph_t;

	typedef struct packed {
		kind_t                     kind;
		logic [IDX_W-1:0]          elem_index;
		logic signed [DATA_W-1:0]  operand_value;
		op_t                       op;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  result_value;
		logic [IDX_W-1:0]          result_index;
		logic                      last;
		stat_t                     status;
	} res_t;

	// j-th column (ascending) of the 3x3 minor that drops column i.
	function automatic logic [1:0] col_of(input logic [1:0] i, input logic [1:0] j);
		return (j < i) ? j : j + 2'd1;
	endfunction

	// Successor modulo three.
	function automatic logic [1:0] next3(input logic [1:0] k);
		return (k == 2'd2) ? 2'd0 : k + 2'd1;
	endfunction

endpackage

// ===== sv/m4a_mul.sv =====
// Shared serial signed multiplier, one DIG_W-bit digit of the multiplier per cycle.
// Depends on m4a_pkg.
module m4a_mul import m4a_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [IW-1:0]  a,
	input  logic signed [IW-1:0]  b,
	output logic                  done,
	output logic signed [PW-1:0]  prod
);

	localparam int CW = $clog2(NDIG + 1);

	logic [IW-1:0]       am_q;
	logic [MB_W-1:0]     bm_q;
	logic [PW-1:0]       pm_q;
	logic                neg_q;
	logic                run_q;
	logic [CW-1:0]       cnt_q;
	logic [IW-1:0]       a_mag;
	logic [IW-1:0]       b_mag;
	logic [IW+DIG_W-1:0] pp;

	assign a_mag = a[IW-1] ? IW'(-a) : IW'(a);
	assign b_mag = b[IW-1] ? IW'(-b) : IW'(b);
	assign pp    = am_q * bm_q[MB_W-1 -: DIG_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == CW'(NDIG)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			am_q  <= a_mag;
			bm_q  <= MB_W'(b_mag);
			pm_q  <= '0;
			neg_q <= a[IW-1] ^ b[IW-1];
		end else if (run_q) begin
			if (cnt_q == CW'(NDIG)) begin
				// apply the sign once the magnitude is complete
				prod <= neg_q ? -$signed(pm_q) : $signed(pm_q);
			end else begin
				pm_q <= (pm_q << DIG_W) + PW'(pp);
				bm_q <= bm_q << DIG_W;
			end
		end
	end

endmodule

// ===== sv/m4a_div.sv =====
// Restoring divider for (num * 2^FRAC_BITS) / den, one quotient bit per cycle,
// truncated toward zero and saturated to the data range. Depends on m4a_pkg.
module m4a_div import m4a_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DATA_W-1:0] num,
	input  logic signed [DATA_W-1:0] den,
	output logic                     done,
	output logic signed [DATA_W-1:0] quot,
	output logic                     sat
);

	localparam int NW = DATA_W + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);
	localparam logic [NW-1:0] LIM_N = NW'(1) << (DATA_W - 1);
	localparam logic [NW-1:0] LIM_P = LIM_N - NW'(1);

	logic [NW-1:0]     num_q;
	logic [NW-1:0]     quo_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] den_q;
	logic              neg_q;
	logic              run_q;
	logic [CW-1:0]     cnt_q;
	logic [DATA_W-1:0] n_mag;
	logic [DATA_W-1:0] d_mag;
	logic [DATA_W:0]   remx;
	logic [DATA_W:0]   rdiff;
	logic              ge;
	logic [NW-1:0]     lim;
	logic [NW-1:0]     qmag;

	assign n_mag = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
	assign d_mag = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
	assign remx  = {rem_q, num_q[NW-1]};
	assign rdiff = remx - {1'b0, den_q};
	assign ge    = (remx >= {1'b0, den_q});
	assign lim   = neg_q ? LIM_N : LIM_P;
	assign qmag  = (quo_q > lim) ? lim : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == CW'(NW)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= NW'(n_mag) << FRAC_BITS;
			den_q <= d_mag;
			neg_q <= num[DATA_W-1] ^ den[DATA_W-1];
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			if (cnt_q == CW'(NW)) begin
				sat  <= (quo_q > lim);
				quot <= neg_q ? -$signed(qmag[DATA_W-1:0]) : $signed(qmag[DATA_W-1:0]);
			end else begin
				rem_q <= ge ? rdiff[DATA_W-1:0] : remx[DATA_W-1:0];
				quo_q <= {quo_q[NW-2:0], ge};
				num_q <= num_q << 1;
			end
		end
	end

endmodule

// ===== sv/matrix4_alu.sv =====
// Top level of the 4x4 fixed-point matrix unit: element memories, sequencer,
// result register. Depends on m4a_pkg, m4a_mul and m4a_div.
//
// A request is taken on a clock edge with start high and busy low. Loads of an A
// or B element leave busy low. An operation raises busy until
// its last result has been issued; each result appears on result for exactly one
// cycle with done high and cannot be held off, so the receiver must take it then.
// Results arrive in row-major order, last marking the final one. Divide by zero
// issues zero results without reads; otherwise each element is first read from the
// element memories (one registered read). Add, sub and transpose issue it from that
// read; scale takes one product of the shared serial multiplier (8 multiplier bits
// per cycle), A times B four products an element and the determinant 40 products;
// divide uses the one-bit-per-cycle divider.
module matrix4_alu import m4a_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output res_t result
);

	localparam logic signed [AW-1:0] LIM_A  = AW'(1) <<< LIM_EXP;
	localparam logic signed [IW-1:0] LIM_I  = IW'(1) <<< LIM_EXP;
	localparam logic signed [IW-1:0] DMAX_I = (IW'(1) <<< (DATA_W - 1)) - IW'(1);
	localparam logic signed [IW-1:0] DMIN_I = -DMAX_I - IW'(1);

	// element memories with per-entry valid bits; an unwritten entry reads as zero
	logic [DATA_W-1:0]    mem_a [NUM_ELEMS];
	logic [DATA_W-1:0]    mem_b [NUM_ELEMS];
	logic [NUM_ELEMS-1:0] va_q, vb_q;
	logic [DATA_W-1:0]    a0_q, a1_q, b_q;
	logic                 a0v_q, a1v_q, bv_q;
	logic [IDX_W-1:0]     ra0, ra1, rb;

	state_t               st_q, st_d;
	op_t                  op_q;
	dph_t                 ph_q;
	logic [IDX_W-1:0]     elem_q;
	logic [1:0]           k_q;
	logic                 sat_q;
	logic signed [DATA_W-1:0] scal_q;
	logic signed [AW-1:0] acc_q, acc2_q, acc3_q;
	logic signed [IW-1:0] m_q;

	logic                 accept;
	logic [1:0]           di;
	logic [1:0]           c_k, c1, c2;
	logic signed [DATA_W-1:0] a0s, a1s, bs;
	logic signed [IW-1:0] a0x, a1x, bx, sx;
	logic signed [IW-1:0] mx, my;
	logic                 mul_start, div_start;
	logic                 mul_done, div_done, unit_done;
	logic signed [PW-1:0] prod;
	logic signed [DATA_W-1:0] div_q;
	logic                 div_sat;
	logic signed [AW-1:0] base, sum, sh;
	logic signed [IW-1:0] scv, esum, dci;
	logic                 scs, dcs;
	logic signed [DATA_W-1:0] dco;

	logic                 emit, adv, em_sat, em_last, em_divz;
	logic signed [DATA_W-1:0] em_val;
	logic [IDX_W-1:0]     em_idx;

	assign accept = start && !busy;
	assign busy   = (st_q != S_IDLE);

	// ---------------- memories ----------------
	always_ff @(posedge clk) begin
		if (accept && req.kind == KIND_LOAD_A)
			mem_a[req.elem_index] <= req.operand_value;
		if (accept && req.kind == KIND_LOAD_B)
			mem_b[req.elem_index] <= req.operand_value;
		a0_q <= mem_a[ra0];
		a1_q <= mem_a[ra1];
		b_q  <= mem_b[rb];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q  <= '0;
			vb_q  <= '0;
			a0v_q <= 1'b0;
			a1v_q <= 1'b0;
			bv_q  <= 1'b0;
		end else begin
			if (accept && req.kind == KIND_LOAD_A)
				va_q[req.elem_index] <= 1'b1;
			if (accept && req.kind == KIND_LOAD_B)
				vb_q[req.elem_index] <= 1'b1;
			a0v_q <= va_q[ra0];
			a1v_q <= va_q[ra1];
			bv_q  <= vb_q[rb];
		end
	end

	assign a0s = a0v_q ? $signed(a0_q) : '0;
	assign a1s = a1v_q ? $signed(a1_q) : '0;
	assign bs  = bv_q  ? $signed(b_q)  : '0;
	assign a0x = {{(IW-DATA_W){a0s[DATA_W-1]}}, a0s};
	assign a1x = {{(IW-DATA_W){a1s[DATA_W-1]}}, a1s};
	assign bx  = {{(IW-DATA_W){bs[DATA_W-1]}}, bs};
	assign sx  = {{(IW-DATA_W){scal_q[DATA_W-1]}}, scal_q};

	// ---------------- read addresses ----------------
	assign di  = elem_q[1:0];
	assign c_k = col_of(di, k_q);
	assign c1  = col_of(di, next3(k_q));
	assign c2  = col_of(di, next3(next3(k_q)));

	always_comb begin
		ra0 = elem_q;
		ra1 = elem_q;
		rb  = elem_q;
		case (op_q)
			OP_MUL: begin
				ra0 = {elem_q[3:2], k_q};
				rb  = {k_q, elem_q[1:0]};
			end
			OP_TRANS: ra0 = {elem_q[1:0], elem_q[3:2]};
			OP_DET: begin
				case (ph_q)
					PH_MIN0: begin
						ra0 = {2'd2, c1};
						ra1 = {2'd3, c2};
					end
					PH_MIN1: begin
						ra0 = {2'd2, c2};
						ra1 = {2'd3, c1};
					end
					PH_D3:   ra0 = {2'd1, c_k};
					default: ra0 = {2'd0, di};
				endcase
			end
			default: ;
		endcase
	end

	// ---------------- arithmetic units ----------------
	always_comb begin
		mx = a0x;
		my = bx;
		case (op_q)
			OP_SCALE: my = sx;
			OP_DET: begin
				case (ph_q)
					PH_MIN0: my = a1x;
					PH_MIN1: begin
						mx = -a0x;
						my = a1x;
					end
					PH_D3:   my = m_q;
					default: begin
						// cofactor sign alternates along the first row
						mx = di[0] ? -a0x : a0x;
						my = m_q;
					end
				endcase
			end
			default: ;
		endcase
	end

	assign mul_start = (st_q == S_EXEC) &&
		(op_q == OP_MUL || op_q == OP_SCALE || op_q == OP_DET);
	assign div_start = (st_q == S_EXEC) && (op_q == OP_DIV);
	assign unit_done = mul_done || div_done;

	m4a_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mx),
		.b      (my),
		.done   (mul_done),
		.prod   (prod)
	);

	m4a_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (a0s),
		.den    (scal_q),
		.done   (div_done),
		.quot   (div_q),
		.sat    (div_sat)
	);

	// accumulate, floor-shift and clamp to the intermediate limit
	always_comb begin
		base = '0;
		case (op_q)
			OP_MUL: base = acc_q;
			OP_DET: begin
				case (ph_q)
					PH_MIN1: base = acc_q;
					PH_D3:   base = acc2_q;
					PH_D4:   base = acc3_q;
					default: base = '0;
				endcase
			end
			default: ;
		endcase
		sum = base + {{(AW-PW){prod[PW-1]}}, prod};
		sh  = sum >>> FRAC_BITS;
		scs = 1'b0;
		if (sh > LIM_A) begin
			scv = LIM_I;
			scs = 1'b1;
		end else if (sh < -LIM_A) begin
			scv = -LIM_I;
			scs = 1'b1;
		end else begin
			scv = sh[IW-1:0];
		end
	end

	// clamp to the data range
	assign esum = (op_q == OP_SUB) ? a0x - bx : a0x + bx;
	assign dci  = (st_q == S_EXEC) ? esum : scv;

	always_comb begin
		dcs = 1'b0;
		if (dci > DMAX_I) begin
			dco = DMAX_I[DATA_W-1:0];
			dcs = 1'b1;
		end else if (dci < DMIN_I) begin
			dco = DMIN_I[DATA_W-1:0];
			dcs = 1'b1;
		end else begin
			dco = dci[DATA_W-1:0];
		end
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= S_IDLE;
		else
			st_q <= st_d;
	end

	always_comb begin
		st_d    = st_q;
		emit    = 1'b0;
		adv     = 1'b0;
		em_val  = dco;
		em_sat  = 1'b0;
		em_idx  = elem_q;
		em_last = (elem_q == IDX_W'(NUM_ELEMS - 1));
		em_divz = 1'b0;
		case (st_q)
			S_IDLE: begin
				if (accept && req.kind == KIND_START && req.op <= OP_DET)
					st_d = (req.op == OP_DIV && req.operand_value == '0) ? S_DIVZ : S_READ;
			end
			S_DIVZ: begin
				emit    = 1'b1;
				em_divz = 1'b1;
				em_val  = '0;
				adv     = 1'b1;
			end
			S_READ: st_d = S_EXEC;
			S_EXEC: begin
				case (op_q)
					OP_ADD, OP_SUB: begin
						emit   = 1'b1;
						em_sat = dcs;
						adv    = 1'b1;
					end
					OP_TRANS: begin
						emit   = 1'b1;
						em_val = a0s;
						adv    = 1'b1;
					end
					default: st_d = S_WAIT;
				endcase
			end
			S_WAIT: begin
				if (unit_done) begin
					case (op_q)
						OP_SCALE: begin
							emit   = 1'b1;
							em_sat = scs || dcs;
							adv    = 1'b1;
						end
						OP_DIV: begin
							emit   = 1'b1;
							em_val = div_q;
							em_sat = div_sat;
							adv    = 1'b1;
						end
						OP_MUL: begin
							if (k_q == 2'd3) begin
								emit   = 1'b1;
								em_sat = scs || dcs;
								adv    = 1'b1;
							end else begin
								st_d = S_READ;
							end
						end
						OP_DET: begin
							if (ph_q == PH_D4 && di == 2'd3) begin
								emit    = 1'b1;
								em_sat  = sat_q || scs || dcs;
								em_idx  = '0;
								em_last = 1'b1;
								st_d    = S_IDLE;
							end else begin
								st_d = S_READ;
							end
						end
						default: st_d = S_IDLE;
					endcase
				end
			end
			default: st_d = S_IDLE;
		endcase
		if (adv)
			st_d = em_last ? S_IDLE : ((st_q == S_DIVZ) ? S_DIVZ : S_READ);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= OP_MUL;
			ph_q   <= PH_MIN0;
			elem_q <= '0;
			k_q    <= '0;
			sat_q  <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= emit;
			if (st_q == S_IDLE && st_d != S_IDLE) begin
				op_q   <= req.op;
				ph_q   <= PH_MIN0;
				elem_q <= '0;
				k_q    <= '0;
				sat_q  <= 1'b0;
			end
			if (adv)
				elem_q <= elem_q + 1'b1;
			if (st_q == S_WAIT && unit_done) begin
				case (op_q)
					OP_MUL: k_q <= k_q + 1'b1;
					OP_DET: begin
						case (ph_q)
							PH_MIN0: ph_q <= PH_MIN1;
							PH_MIN1: begin
								ph_q  <= PH_D3;
								sat_q <= sat_q || scs;
							end
							PH_D3: begin
								if (k_q == 2'd2) begin
									ph_q  <= PH_D4;
									k_q   <= '0;
									sat_q <= sat_q || scs;
								end else begin
									ph_q <= PH_MIN0;
									k_q  <= k_q + 1'b1;
								end
							end
							default: begin
								ph_q   <= PH_MIN0;
								elem_q <= elem_q + 1'b1;
							end
						endcase
					end
					default: ;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && st_d != S_IDLE) begin
			scal_q <= req.operand_value;
			acc_q  <= '0;
			acc2_q <= '0;
			acc3_q <= '0;
		end
		if (st_q == S_WAIT && unit_done) begin
			case (op_q)
				OP_MUL: acc_q <= (k_q == 2'd3) ? '0 : sum;
				OP_DET: begin
					case (ph_q)
						PH_MIN0: acc_q <= sum;
						PH_MIN1: m_q <= scv;
						PH_D3: begin
							if (k_q == 2'd2) begin
								m_q    <= scv;
								acc2_q <= '0;
							end else begin
								acc2_q <= sum;
							end
						end
						default: acc3_q <= sum;
					endcase
				end
				default: ;
			endcase
		end
		if (emit) begin
			result.result_value <= em_val;
			result.result_index <= em_idx;
			result.last         <= em_last;
			result.status       <= em_divz ? STAT_DIVZ : (em_sat ? STAT_SAT : STAT_OK);
		end
	end

endmodule

// ===== sv/m4a_chk.sv =====
// Port-level checks for matrix4_alu, attached by the bind at the end of the file.
// Depends on m4a_pkg.
module m4a_chk import m4a_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input req_t req,
	input logic busy,
	input logic done,
	input res_t result
);

	// a load request never produces a result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.kind != KIND_START) |=> !done)
		else $error("result after load request");

	// the final result of an operation is not directly followed by another result
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.last) |=> !done)
		else $error("result after last");

	// more results pending keeps the block busy
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.last) |-> busy)
		else $error("idle with results pending");

	// divide by zero returns zero
	a_divz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == STAT_DIVZ) |-> (result.result_value == '0))
		else $error("nonzero divide-by-zero result");

endmodule

bind matrix4_alu m4a_chk u_chk (.*);

// ===== dv/tb.sv =====
// Self-checking testbench for matrix4_alu: drives load and operation requests and
// predicts every result with its own fixed-point model. Depends on m4a_pkg.
`timescale 1ns / 1ps

module tb;
	import m4a_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam longint INTER_LIM = 64'sd1 <<< LIM_EXP;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef logic signed [127:0] wide_t;

	logic  clk;
	logic  arst_n;
	logic  start;
	req_t  req;
	logic  busy;
	logic  done;
	res_t  result;

	longint mat_a[NUM_ELEMS];
	longint mat_b[NUM_ELEMS];
	res_t   pending_results[$];
	int     mismatches;
	int     idle_cycles;
	bit     no_gaps;

	matrix4_alu i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Floor shift of an exact sum, then clamp to the intermediate limit.
	function automatic longint shift_clamp(input wide_t v, inout bit sat);
		wide_t s;
		s = v >>> FRAC;
		if (s > INTER_LIM) begin
			sat = 1'b1;
			return INTER_LIM;
		end
		if (s < -INTER_LIM) begin
			sat = 1'b1;
			return -INTER_LIM;
		end
		return s[63:0];
	endfunction

	function automatic longint sum_products(input longint x[4], input longint y[4],
			input int n, inout bit sat);
		wide_t acc;
		acc = 0;
		for (int i = 0; i < n; i++)
			acc += wide_t'(x[i]) * wide_t'(y[i]);
		return shift_clamp(acc, sat);
	endfunction

	function automatic longint clamp_word(input longint v, inout bit sat);
		longint hi;
		hi = (64'sd1 <<< (DATA_W - 1)) - 1;
		if (v > hi) begin
			sat = 1'b1;
			return hi;
		end
		if (v < -hi - 1) begin
			sat = 1'b1;
			return -hi - 1;
		end
		return v;
	endfunction

	function automatic longint quotient(input longint a, input longint d, inout bit sat);
		logic [127:0] num, q, lim;
		bit neg;
		neg = (a < 0) != (d < 0);
		num = 128'((a < 0) ? -a : a) << FRAC;
		q = num / 128'((d < 0) ? -d : d);
		lim = (128'd1 << (DATA_W - 1)) - (neg ? 0 : 1);
		if (q > lim) begin
			sat = 1'b1;
			q = lim;
		end
		return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	// 3x3 minor of rows 1..3, dropping column skip.
	function automatic longint minor3(input int skip, inout bit sat);
		int c[3];
		longint x[4], y[4], p[4], q[4];
		int n;
		n = 0;
		for (int j = 0; j < 4; j++)
			if (j != skip) begin
				c[n] = j;
				n++;
			end
		x = '{default: 0};
		y = '{default: 0};
		p = '{default: 0};
		q = '{default: 0};
		for (int k = 0; k < 3; k++) begin
			p[0] = mat_a[8 + c[(k + 1) % 3]];
			q[0] = mat_a[12 + c[(k + 2) % 3]];
			p[1] = -mat_a[8 + c[(k + 2) % 3]];
			q[1] = mat_a[12 + c[(k + 1) % 3]];
			x[k] = mat_a[4 + c[k]];
			y[k] = sum_products(p, q, 2, sat);
		end
		return sum_products(x, y, 3, sat);
	endfunction

	task automatic push_result(input longint v, input int idx, input bit is_last,
			input stat_t st);
		res_t r;
		r.result_value = v[DATA_W-1:0];
		r.result_index = idx[IDX_W-1:0];
		r.last = is_last;
		r.status = st;
		pending_results.insert(pending_results.size(), r);
	endtask

	// Update the stored matrices and queue the results one request causes.
	task automatic predict_request(input req_t r);
		longint val, v;
		longint x[4], y[4];
		bit sat;
		val = r.operand_value;
		x = '{default: 0};
		y = '{default: 0};
		case (r.kind)
			KIND_LOAD_A: mat_a[r.elem_index] = val;
			KIND_LOAD_B: mat_b[r.elem_index] = val;
			KIND_START: begin
				if (r.op == OP_DET) begin
					sat = 1'b0;
					for (int i = 0; i < 4; i++) begin
						x[i] = (i & 1) ? -mat_a[i] : mat_a[i];
						y[i] = minor3(i, sat);
					end
					v = clamp_word(sum_products(x, y, 4, sat), sat);
					push_result(v, 0, 1'b1, sat ? STAT_SAT : STAT_OK);
				end else if (r.op == OP_DIV && val == 0) begin
					for (int i = 0; i < NUM_ELEMS; i++)
						push_result(0, i, i == NUM_ELEMS - 1, STAT_DIVZ);
				end else if (r.op <= OP_TRANS) begin
					for (int i = 0; i < NUM_ELEMS; i++) begin
						sat = 1'b0;
						case (r.op)
							OP_MUL: begin
								for (int k = 0; k < 4; k++) begin
									x[k] = mat_a[(i / 4) * 4 + k];
									y[k] = mat_b[k * 4 + i % 4];
								end
								v = sum_products(x, y, 4, sat);
							end
							OP_ADD: v = mat_a[i] + mat_b[i];
							OP_SUB: v = mat_a[i] - mat_b[i];
							OP_SCALE: begin
								x[0] = mat_a[i];
								y[0] = val;
								v = sum_products(x, y, 1, sat);
							end
							OP_DIV: v = quotient(mat_a[i], val, sat);
							default: v = mat_a[(i % 4) * 4 + i / 4];
						endcase
						v = clamp_word(v, sat);
						push_result(v, i, i == NUM_ELEMS - 1, sat ? STAT_SAT : STAT_OK);
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_request(input logic [1:0] kind, input int idx, input logic [31:0] val,
			input logic [2:0] op);
		int gap;
		req_t r;
		gap = no_gaps ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		r.kind = kind_t'(kind);
		r.elem_index = idx[IDX_W-1:0];
		r.operand_value = val;
		r.op = op_t'(op);
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		predict_request(r);
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] random_operand();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'h8000_0000 | $urandom_range(0, 3);
			2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
			default: return 32'($signed($urandom_range(0, 8 << FRAC)) - (4 << FRAC));
		endcase
	endfunction

	task automatic load_both(input logic [31:0] va, input logic [31:0] vb);
		for (int i = 0; i < NUM_ELEMS; i++) begin
			send_request(KIND_LOAD_A, i, va, 3'($urandom_range(0, 7)));
			send_request(KIND_LOAD_B, i, vb, 3'($urandom_range(0, 7)));
		end
	endtask

	// Full-scale elements: scale, A times B and divide all saturate, divide by zero flags all.
	task automatic test_extremes();
		load_both(32'h8000_0000, 32'h7FFF_FFFF);
		send_request(KIND_START, 0, 32'h8000_0000, OP_SCALE);
		send_request(KIND_START, 0, 32'h7FFF_FFFF, OP_MUL);
		send_request(KIND_START, 0, 32'd0, OP_DIV);
		send_request(KIND_START, 0, 32'd1, OP_DIV);
	endtask

	task automatic test_each_op();
		for (int i = 0; i < NUM_ELEMS; i++) begin
			send_request(KIND_LOAD_A, i, random_operand(), OP_MUL);
			send_request(KIND_LOAD_B, i, random_operand(), OP_MUL);
		end
		for (int op = OP_MUL; op <= OP_DET; op++)
			send_request(KIND_START, $urandom_range(0, 15), 32'h0003_8000, 3'(op));
	endtask

	// Unknown kind and unknown operation are dropped without a result.
	task automatic test_ignored();
		send_request(2'd3, 5, 32'hFFFF_FFFF, OP_ADD);
		send_request(KIND_START, 0, 32'd0, 3'd7);
		send_request(KIND_START, 0, 32'd0, OP_ADD);
	endtask

	task automatic test_random(input int n_items);
		int sent;
		int run;
		sent = 0;
		while (sent < n_items) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			run = $urandom_range(1, 12);
			for (int i = 0; i < run; i++) begin
				send_request(2'($urandom_range(0, 1)), $urandom_range(0, 15),
					random_operand(), 3'($urandom_range(0, 7)));
				sent++;
			end
			if ($urandom_range(0, 15) == 0)
				send_request(2'd3, $urandom_range(0, 15), $urandom,
					3'($urandom_range(0, 7)));
			else if ($urandom_range(0, 15) == 0)
				send_request(KIND_START, 0, $urandom, 3'd7);
			else
				send_request(KIND_START, $urandom_range(0, 15),
					($urandom_range(0, 7) == 0) ? 32'd0 : random_operand(),
					3'($urandom_range(OP_MUL, OP_DET)));
			sent++;
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		mismatches = 0;
		no_gaps = 1'b0;
		start = 1'b0;
		req = '0;
		arst_n = 1'b0;
		foreach (mat_a[i]) begin
			mat_a[i] = 0;
			mat_b[i] = 0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_request(KIND_START, 0, 32'd0, OP_DET);
		test_extremes();
		test_each_op();
		test_ignored();
		test_random(320);
		start <= 1'b0;
		wait_drained();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("[matrix4_alu] OK");
		else
			$display("[matrix4_alu] ERROR");
		$finish;
	end

	// Compare each issued result with the oldest expectation.
	always @(posedge clk) begin
		res_t exp_res;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: value %h index %0d", result.result_value,
						result.result_index);
			end else begin
				exp_res = pending_results.pop_front();
				if (result !== exp_res) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp val %h idx %0d last %b st %0d, got val %h idx %0d last %b st %0d",
							exp_res.result_value, exp_res.result_index, exp_res.last,
							exp_res.status, result.result_value, result.result_index,
							result.last, result.status);
				end
			end
		end
	end

	// Count cycles without a request taken or a result issued.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[matrix4_alu] ERROR");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

endmodule

// ===== filelist.f =====
sv/m4a_pkg.sv
sv/m4a_mul.sv
sv/m4a_div.sv
sv/matrix4_alu.sv
sv/m4a_chk.sv
dv/tb.sv
